[hdl/encmt_pkg.sv]
package encmt_pkg;

  // Register indexes on the configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 17;
  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_TICKS   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_M_THRESHOLD    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_COUNTS_PER_REV = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_FILTER_ALPHA   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_STALE_LIMIT    = 3'd4;

  // Divider widths: numerator |sum|*1000, denominator counts_per_rev*time
  localparam int unsigned NUM_W = 42;
  localparam int unsigned DEN_W = 48;
  localparam int unsigned QUO_W = 31;
  localparam logic [9:0]  MS_PER_S = 10'd1000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MUL,
    ST_DIV_START,
    ST_DIV,
    ST_SIGN,
    ST_FILT_MUL,
    ST_FILT_ADD
  } state_e;

  typedef enum logic [1:0] {
    METHOD_M      = 2'd0,
    METHOD_T      = 2'd1,
    METHOD_EXTRAP = 2'd2,
    METHOD_NONE   = 2'd3
  } method_e;

  typedef struct packed {
    logic restart;
    logic tick;
    logic decide;
    logic mul;
    logic div_start;
    logic div_step;
    logic sign;
    logic filt_mul;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic win_end;
    logic do_div;
    logic capped;
    logic div_last;
    logic out_busy;
  } sts_t;

endpackage

[hdl/encmt_ctrl.sv]
module encmt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_restart_i,
  output logic             in_ready_o,
  input  encmt_pkg::sts_t  sts_i,
  output encmt_pkg::cmd_t  cmd_o
);

  encmt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= encmt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      encmt_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_restart_i) begin
            cmd_o.restart = 1'b1;
          end else begin
            cmd_o.tick = 1'b1;
            state_d    = encmt_pkg::ST_DECIDE;
          end
        end
      end
      encmt_pkg::ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        if (!sts_i.win_end) begin
          state_d = encmt_pkg::ST_IDLE;
        end else if (sts_i.do_div) begin
          state_d = encmt_pkg::ST_MUL;
        end else begin
          state_d = encmt_pkg::ST_FILT_MUL;
        end
      end
      encmt_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = encmt_pkg::ST_DIV_START;
      end
      encmt_pkg::ST_DIV_START: begin
        cmd_o.div_start = 1'b1;
        state_d = sts_i.capped ? encmt_pkg::ST_SIGN : encmt_pkg::ST_DIV;
      end
      encmt_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = encmt_pkg::ST_SIGN;
        end
      end
      encmt_pkg::ST_SIGN: begin
        cmd_o.sign = 1'b1;
        state_d    = encmt_pkg::ST_FILT_MUL;
      end
      encmt_pkg::ST_FILT_MUL: begin
        cmd_o.filt_mul = 1'b1;
        state_d        = encmt_pkg::ST_FILT_ADD;
      end
      encmt_pkg::ST_FILT_ADD: begin
        // hold until the output register is free
        if (!sts_i.out_busy) begin
          cmd_o.publish = 1'b1;
          state_d       = encmt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = encmt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[hdl/encmt_dp.sv]
module encmt_dp #(
  parameter int unsigned SPEED_FRAC_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [encmt_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [encmt_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic [15:0]                      pulse_delta_i,
  input  encmt_pkg::cmd_t                  cmd_i,
  output encmt_pkg::sts_t                  sts_o,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [31:0]                      speed_o,
  output logic [31:0]                      unfilt_speed_o,
  output logic [1:0]                       method_o
);

  localparam int unsigned NUM_W = encmt_pkg::NUM_W;
  localparam int unsigned DEN_W = encmt_pkg::DEN_W;
  localparam int unsigned QUO_W = encmt_pkg::QUO_W;
  localparam int unsigned XW    = NUM_W + SPEED_FRAC_BITS;
  localparam int unsigned CNT_W = $clog2(QUO_W);

  // configuration
  logic [15:0] win_q, cpr_q, stale_q;
  logic [14:0] thr_q;
  logic [16:0] alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= 16'd1;
      thr_q   <= 15'd0;
      cpr_q   <= 16'd1024;
      alpha_q <= 17'd2114;
      stale_q <= 16'd1000;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        encmt_pkg::REG_WINDOW_TICKS:   win_q   <= cfg_wdata_i[15:0];
        encmt_pkg::REG_M_THRESHOLD:    thr_q   <= cfg_wdata_i[14:0];
        encmt_pkg::REG_COUNTS_PER_REV: cpr_q   <= cfg_wdata_i[15:0];
        encmt_pkg::REG_FILTER_ALPHA:   alpha_q <= cfg_wdata_i;
        encmt_pkg::REG_STALE_LIMIT:    stale_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // measurement state
  logic [31:0] ms_q, prev_q, latest_q, sum_q;
  logic [15:0] tiw_q;
  logic        tvalid_q, dir_pos_q;
  logic signed [31:0] filt_q;

  // working registers
  logic [31:0]       base_q, factor_q;
  logic              neg_q, capped_q;
  logic [1:0]        method_q;
  logic [NUM_W-1:0]  num_q;
  logic [DEN_W-1:0]  den_q, rem_q;
  logic [QUO_W-1:0]  quo_q;
  logic [CNT_W-1:0]  cnt_q;
  logic signed [31:0] raw_q;
  logic signed [50:0] prod_q;

  // tick
  logic [31:0] ms_inc, delta_ext;
  assign ms_inc    = ms_q + 32'd1;
  assign delta_ext = {{16{pulse_delta_i[15]}}, pulse_delta_i};

  // window end decision
  logic [31:0] absum, elapsed, interval;
  logic [15:0] win_eff, cpr_eff;
  logic        m_hit, stale, do_div;
  logic [31:0] base_d, factor_d;
  logic        neg_d;
  logic [1:0]  method_d;

  assign absum    = sum_q[31] ? (32'd0 - sum_q) : sum_q;
  assign m_hit    = absum >= {17'd0, thr_q};
  assign elapsed  = ms_q - latest_q;
  assign stale    = elapsed > {16'd0, stale_q};
  assign interval = (latest_q > prev_q) ? (latest_q - prev_q) : 32'd1;
  assign win_eff  = (win_q == 16'd0) ? 16'd1 : win_q;
  assign cpr_eff  = (cpr_q == 16'd0) ? 16'd1 : cpr_q;

  always_comb begin
    do_div   = 1'b0;
    base_d   = 32'd1;
    factor_d = elapsed;
    neg_d    = !dir_pos_q;
    method_d = encmt_pkg::METHOD_NONE;
    if (m_hit) begin
      do_div   = 1'b1;
      base_d   = absum;
      factor_d = {16'd0, win_eff};
      neg_d    = sum_q[31];
      method_d = encmt_pkg::METHOD_M;
    end else if (tvalid_q) begin
      if (sum_q == 32'd0) begin
        if (!stale) begin
          method_d = encmt_pkg::METHOD_EXTRAP;
          do_div   = (elapsed != 32'd0);
        end
      end else begin
        do_div   = 1'b1;
        factor_d = interval;
        method_d = encmt_pkg::METHOD_T;
      end
    end
  end

  // divider: floor(num * 2^F / den), capped at 2^31
  logic [XW-1:0]     x_full;
  logic [XW-QUO_W-1:0] x_hi;
  logic [QUO_W-1:0]  x_lo;
  logic              cap_hit, ge;
  logic [DEN_W:0]    rem2, rem_sub;

  assign x_full  = {num_q, {SPEED_FRAC_BITS{1'b0}}};
  assign x_hi    = x_full[XW-1:QUO_W];
  assign x_lo    = x_full[QUO_W-1:0];
  assign cap_hit = {{QUO_W{1'b0}}, x_hi} >= {{(XW-DEN_W){1'b0}}, den_q};
  assign rem2    = {rem_q, x_lo[cnt_q]};
  assign ge      = rem2 >= {1'b0, den_q};
  assign rem_sub = rem2 - {1'b0, den_q};

  logic [31:0] mag, raw_d;
  assign mag   = capped_q ? 32'h8000_0000 : {1'b0, quo_q};
  assign raw_d = neg_q ? (32'd0 - mag) : (mag[31] ? 32'h7FFF_FFFF : mag);

  // filter
  logic [16:0]        alpha_eff;
  logic signed [32:0] diff;
  logic signed [17:0] alpha_s;
  logic signed [34:0] step;
  logic signed [35:0] acc;
  logic signed [31:0] filt_d;

  assign alpha_eff = (alpha_q > 17'd65536) ? 17'd65536 : alpha_q;
  assign alpha_s   = {1'b0, alpha_eff};
  assign diff      = {raw_q[31], raw_q} - {filt_q[31], filt_q};
  assign step      = prod_q[50:16];
  assign acc       = {{4{filt_q[31]}}, filt_q} + {step[34], step};

  always_comb begin
    if (acc[35:31] == 5'b00000 || acc[35:31] == 5'b11111) begin
      filt_d = acc[31:0];
    end else if (acc[35]) begin
      filt_d = 32'sh8000_0000;
    end else begin
      filt_d = 32'sh7FFF_FFFF;
    end
  end

  assign sts_o.win_end  = tiw_q >= win_q;
  assign sts_o.do_div   = do_div;
  assign sts_o.capped   = cap_hit;
  assign sts_o.div_last = (cnt_q == '0);
  assign sts_o.out_busy = out_valid_o && !out_ready_i;

  // measurement state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_q      <= '0;
      tiw_q     <= '0;
      sum_q     <= '0;
      prev_q    <= '0;
      latest_q  <= '0;
      tvalid_q  <= 1'b0;
      dir_pos_q <= 1'b0;
      filt_q    <= '0;
    end else if (cmd_i.restart) begin
      ms_q      <= '0;
      tiw_q     <= '0;
      sum_q     <= '0;
      prev_q    <= '0;
      latest_q  <= '0;
      tvalid_q  <= 1'b0;
      dir_pos_q <= 1'b0;
      filt_q    <= '0;
    end else if (cmd_i.tick) begin
      ms_q  <= ms_inc;
      sum_q <= sum_q + delta_ext;
      tiw_q <= tiw_q + 16'd1;
      if (pulse_delta_i != 16'd0) begin
        prev_q    <= latest_q;
        latest_q  <= ms_inc;
        dir_pos_q <= !pulse_delta_i[15];
        tvalid_q  <= 1'b1;
      end
    end else if (cmd_i.decide && sts_o.win_end) begin
      tiw_q <= '0;
      sum_q <= '0;
      // drop the interval state once it has gone stale
      if (!m_hit && tvalid_q && sum_q == 32'd0 && stale) begin
        tvalid_q <= 1'b0;
      end
    end else if (cmd_i.publish) begin
      filt_q <= filt_d;
    end
  end

  // datapath working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      base_q   <= base_d;
      factor_q <= factor_d;
      neg_q    <= neg_d;
      method_q <= method_d;
      raw_q    <= '0;
    end
    if (cmd_i.mul) begin
      num_q <= NUM_W'(base_q) * NUM_W'(encmt_pkg::MS_PER_S);
      den_q <= DEN_W'(cpr_eff) * DEN_W'(factor_q);
    end
    if (cmd_i.div_start) begin
      capped_q <= cap_hit;
      rem_q    <= DEN_W'(x_hi);
      quo_q    <= '0;
      cnt_q    <= CNT_W'(QUO_W - 1);
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? rem_sub[DEN_W-1:0] : rem2[DEN_W-1:0];
      quo_q <= {quo_q[QUO_W-2:0], ge};
      cnt_q <= cnt_q - CNT_W'(1);
    end
    if (cmd_i.sign) begin
      raw_q <= raw_d;
    end
    if (cmd_i.filt_mul) begin
      prod_q <= diff * alpha_s;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.publish) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      speed_o        <= filt_d;
      unfilt_speed_o <= raw_q;
      method_o       <= method_q;
    end
  end

endmodule

[hdl/encoder_mt_speed_estimator.sv]
// Channel  | Direction | Handshake             | Payload
// s_axis   | in        | s_axis_tvalid/tready  | tdata: pulse_delta; tuser: action
// m_axis   | out       | m_axis_tvalid/tready  | tdata: speed, unfilt_speed; tuser: method
// cfg      | in        | cfg_we_i (no wait)    | cfg_addr_i index, cfg_wdata_i value
//
// A tick inside a window passes through IDLE and DECIDE. A window end that
// divides goes on through MUL, DIV_START, DIV (the shared bit-serial divider,
// one quotient bit per cycle), SIGN, FILT_MUL, FILT_ADD. A restart gives no transfer.
// Reset is asynchronous, active low; config and state registers return to defaults.
// A finished result waits in the output register while the next tick is
// taken; the block stalls only when a second result meets a full register.
module encoder_mt_speed_estimator #(
  parameter int unsigned SPEED_FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] pulse_delta
  input  logic        s_axis_tuser,   // [0] action (restart)

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [31:0] speed, [63:32] unfilt_speed
  output logic [1:0]  m_axis_tuser,   // [1:0] method

  input  logic                             cfg_we_i,
  input  logic [encmt_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [encmt_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  encmt_pkg::cmd_t cmd;
  encmt_pkg::sts_t sts;
  logic [31:0]     speed, unfilt_speed;

  encmt_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_restart_i (s_axis_tuser),
    .in_ready_o   (s_axis_tready),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  encmt_dp #(
    .SPEED_FRAC_BITS (SPEED_FRAC_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .pulse_delta_i  (s_axis_tdata),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .speed_o        (speed),
    .unfilt_speed_o (unfilt_speed),
    .method_o       (m_axis_tuser)
  );

  // pack result fields, speed in the low word
  assign m_axis_tdata = {unfilt_speed, speed};

`ifndef SYNTHESIS
  // never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.publish |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("result published over a stalled transfer");

  // the controller issues at most one command per cycle
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd))
    else $error("more than one datapath command");

  // no estimate means zero unfiltered speed
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == encmt_pkg::METHOD_NONE) |-> m_axis_tdata[63:32] == 32'd0)
    else $error("nonzero unfiltered speed without an estimate");
`endif

endmodule

[tb/encoder_mt_speed_estimator_test.sv]
module encoder_mt_speed_estimator_test;

  localparam int unsigned FRAC = 16;
  // Margin for the worst window end to finish before a register write
  localparam int unsigned SETTLE = 60;

  typedef struct {
    bit          restart;
    logic [15:0] delta;
  } tick_t;

  typedef struct {
    logic [31:0]        speed;
    logic [31:0]        raw;
    encmt_pkg::method_e meth;
  } speed_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // [15:0] pulse_delta
  logic        s_axis_tuser = 1'b0; // [0] action (restart)
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;       // [31:0] speed, [63:32] unfilt_speed
  logic [1:0]  m_axis_tuser;       // [1:0] method
  logic                             cfg_we_i = 1'b0;
  logic [encmt_pkg::CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [encmt_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;

  encoder_mt_speed_estimator #(.SPEED_FRAC_BITS(FRAC)) dut (.*);

  always #5 clk_i = ~clk_i;

  // Shadow registers, reset values of the block
  int unsigned win_ticks = 1, m_thresh = 0, cpr_reg = 1024, alpha_reg = 2114, stale_lim = 1000;

  // Estimator state
  int unsigned ms_count, prev_pulse, last_pulse;
  int          pulse_sum, filt_speed;
  logic [15:0] win_pos;
  bit          pulse_seen, dir_pos;

  tick_t  tick_queue[$];
  speed_t speed_due[$];
  int     send_idle_pct, recv_stall_pct;
  int     errors;

  // floor(n * 2^FRAC / d), capped at 2^31
  function automatic longint unsigned frac_div(longint unsigned n, longint unsigned d);
    longint unsigned q;
    q = (n << FRAC) / d;
    return (q >= (64'd1 << 31)) ? (64'd1 << 31) : q;
  endfunction

  function automatic longint signed apply_sign(longint unsigned mag, bit neg);
    if (neg) return (mag >= (64'd1 << 31)) ? -longint'(64'd1 << 31) : -longint'(mag);
    return (mag > 64'd2147483647) ? 64'sd2147483647 : longint'(mag);
  endfunction

  function automatic int clamp32(longint signed v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return int'(v);
  endfunction

  task automatic estimate_speed(tick_t t);
    longint signed      raw, prod;
    longint unsigned    cpr, win;
    int unsigned        absum, interval, elapsed, alpha;
    int                 delta;
    encmt_pkg::method_e meth;
    speed_t             r;
    raw = 0;
    meth = encmt_pkg::METHOD_NONE;
    if (t.restart) begin
      ms_count = 0; win_pos = 0; pulse_sum = 0; prev_pulse = 0; last_pulse = 0;
      pulse_seen = 0; dir_pos = 0; filt_speed = 0;
      return;
    end
    delta = $signed(t.delta);
    ms_count++;
    if (delta != 0) begin
      prev_pulse = last_pulse;
      last_pulse = ms_count;
      dir_pos = delta > 0;
      pulse_seen = 1;
    end
    pulse_sum = pulse_sum + delta;
    win_pos = win_pos + 16'd1;
    if (win_pos < win_ticks) return;

    cpr = (cpr_reg != 0) ? cpr_reg : 1;
    win = (win_ticks != 0) ? win_ticks : 1;
    absum = (pulse_sum < 0) ? 32'(-pulse_sum) : pulse_sum;
    if (absum >= m_thresh) begin
      raw = apply_sign(frac_div(longint'(absum) * 1000, cpr * win), pulse_sum < 0);
      meth = encmt_pkg::METHOD_M;
    end else if (pulse_seen) begin
      if (pulse_sum == 0) begin
        elapsed = ms_count - last_pulse;
        if (elapsed > stale_lim) begin
          pulse_seen = 0;  // stale: drop the interval state
        end else begin
          meth = encmt_pkg::METHOD_EXTRAP;
          if (elapsed > 0) raw = apply_sign(frac_div(1000, cpr * elapsed), !dir_pos);
        end
      end else begin
        interval = (last_pulse > prev_pulse) ? last_pulse - prev_pulse : 1;
        raw = apply_sign(frac_div(1000, cpr * interval), !dir_pos);
        meth = encmt_pkg::METHOD_T;
      end
    end
    alpha = (alpha_reg > 65536) ? 65536 : alpha_reg;
    prod = (raw - longint'(filt_speed)) * longint'(alpha);
    filt_speed = clamp32(longint'(filt_speed) + (prod >>> 16));  // floor shift
    win_pos = 0;
    pulse_sum = 0;
    r.speed = filt_speed;
    r.raw = clamp32(raw);
    r.meth = meth;
    speed_due.push_back(r);
  endtask

  // Driver: predict each accepted transfer, then offer the next tick or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) estimate_speed('{s_axis_tuser, s_axis_tdata});
      if (tick_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        tick_t t;
        t = tick_queue.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= t.restart;
        s_axis_tdata  <= t.delta;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: compare each result transfer with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (speed_due.size() == 0) begin
          $error("unexpected result speed=%h raw=%h", m_axis_tdata[31:0], m_axis_tdata[63:32]);
          errors++;
        end else begin
          speed_t e;
          e = speed_due.pop_front();
          if (m_axis_tdata[31:0] !== e.speed) begin
            $error("speed: expected %0d actual %0d", $signed(e.speed), $signed(m_axis_tdata[31:0]));
            errors++;
          end
          if (m_axis_tdata[63:32] !== e.raw) begin
            $error("unfilt_speed: expected %0d actual %0d", $signed(e.raw),
                   $signed(m_axis_tdata[63:32]));
            errors++;
          end
          if (m_axis_tuser !== e.meth) begin
            $error("method: expected %0d actual %0d", e.meth, m_axis_tuser);
            errors++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Write one register on the idle block and mirror it in the shadow copy
  task automatic write_reg(logic [encmt_pkg::CFG_ADDR_W-1:0] idx, int unsigned val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val[encmt_pkg::CFG_DATA_W-1:0];
    case (idx)
      encmt_pkg::REG_WINDOW_TICKS:   win_ticks = val & 32'hffff;
      encmt_pkg::REG_M_THRESHOLD:    m_thresh  = val & 32'h7fff;
      encmt_pkg::REG_COUNTS_PER_REV: cpr_reg   = val & 32'hffff;
      encmt_pkg::REG_FILTER_ALPHA:   alpha_reg = val & 32'h1ffff;
      encmt_pkg::REG_STALE_LIMIT:    stale_lim = val & 32'hffff;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic setup(int unsigned w, int unsigned th, int unsigned c, int unsigned a,
                       int unsigned s);
    write_reg(encmt_pkg::REG_WINDOW_TICKS, w);
    write_reg(encmt_pkg::REG_M_THRESHOLD, th);
    write_reg(encmt_pkg::REG_COUNTS_PER_REV, c);
    write_reg(encmt_pkg::REG_FILTER_ALPHA, a);
    write_reg(encmt_pkg::REG_STALE_LIMIT, s);
  endtask

  task automatic push_tick(bit rs, logic [15:0] d);
    tick_queue.push_back('{rs, d});
  endtask

  // Wait until every tick is taken and every result has come, then let the block settle
  task automatic drain();
    do @(posedge clk_i);
    while (tick_queue.size() > 0 || s_axis_tvalid || speed_due.size() > 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_delta();
    case ($urandom_range(7))
      0, 1, 2, 3: return 16'd0;
      4, 5:       return $urandom_range(1) ? 16'($urandom_range(1, 3)) : -16'($urandom_range(1, 3));
      6:          return 16'($urandom);
      default:    return $urandom_range(1) ? 16'h7fff : 16'h8000;
    endcase
  endfunction

  initial begin
    errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // M method at the delta extremes, one tick per window, restart in between
    setup(1, 0, 1024, 2114, 1000);
    push_tick(0, 16'h7fff); push_tick(0, 16'h8000); push_tick(0, 16'd0);
    push_tick(0, 16'd1); push_tick(1, 16'hffff); push_tick(0, 16'hffff);
    drain();

    // T interval, extrapolation, stale, no pulse, then zero elapsed time
    setup(3, 4, 7, 65536, 4);
    push_tick(0, 16'd1); push_tick(0, 16'd0); push_tick(0, 16'd1);
    push_tick(0, 16'd0); push_tick(0, 16'd0); push_tick(0, 16'd0);
    push_tick(0, 16'd0); push_tick(0, 16'd0); push_tick(0, 16'd0);
    push_tick(0, 16'd0); push_tick(0, 16'd0); push_tick(0, 16'd0);
    push_tick(0, 16'd0); push_tick(0, 16'd2); push_tick(0, 16'hfffe);
    drain();

    // Zero window and zero counts per rev, alpha above one, widest threshold
    setup(0, 32767, 0, 131071, 65535);
    push_tick(0, 16'd3); push_tick(0, 16'hfffd); push_tick(0, 16'h7fff);
    drain();

    // Longest window: ticks accumulate with no result, then restart
    setup(65535, 0, 65535, 0, 1);
    repeat (10) push_tick(0, rand_delta());
    push_tick(1, 16'($urandom));
    drain();

    // Random part, one idling mode per phase, fresh settings every block of ticks
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 66 : (ph == 3) ? 34 : 0;
      recv_stall_pct = (ph == 2) ? 66 : (ph == 3) ? 34 : 0;
      for (int blk = 0; blk < 4; blk++) begin
        setup($urandom_range(3) == 0 ? $urandom_range(0, 12) : $urandom_range(1, 4),
              $urandom_range(3) == 0 ? $urandom_range(32767) : $urandom_range(0, 8),
              $urandom_range(1) ? $urandom_range(65535) : $urandom_range(1, 64),
              $urandom_range(131071),
              $urandom_range(1) ? $urandom_range(65535) : $urandom_range(0, 10));
        repeat (40) push_tick($urandom_range(59) == 0, rand_delta());
        drain();
      end
    end

    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #20000000;
    $display("FAILURE");
    $finish;
  end

endmodule

[filelist.f]
hdl/encmt_pkg.sv
hdl/encmt_ctrl.sv
hdl/encmt_dp.sv
hdl/encoder_mt_speed_estimator.sv
tb/encoder_mt_speed_estimator_test.sv
